// ----- src/lir_pkg.sv -----
package lir_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int NUM_LANES    = 4;
    localparam int SAMPLE_W     = 16;
    localparam int FRAC_W       = 32;
    localparam int STEP_W       = 36;
    localparam int NCH_W        = 3;
    localparam int CARRY_W      = 5;
    localparam int RESULT_CAP   = 64;
    localparam int K_W          = $clog2(RESULT_CAP);
    localparam int CH_W         = $clog2(NUM_LANES);
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = STEP_W;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CH  = CFG_IDX_W'(1);

    localparam logic [STEP_W-1:0] PHASE_STEP_RST = STEP_W'(64'd3946001203);
    localparam logic [NCH_W-1:0]  ACTIVE_CH_RST  = NCH_W'(1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_ch0;
        logic signed [SAMPLE_W-1:0] sample_ch1;
        logic signed [SAMPLE_W-1:0] sample_ch2;
        logic signed [SAMPLE_W-1:0] sample_ch3;
    } t_in_frame;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_ch0;
        logic signed [SAMPLE_W-1:0] out_ch1;
        logic signed [SAMPLE_W-1:0] out_ch2;
        logic signed [SAMPLE_W-1:0] out_ch3;
        logic                       last_of_run;
    } t_out_frame;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_LOAD
    } t_state;

endpackage

// ----- src/lir_interp_unit.sv -----
module lir_interp_unit (
    input  logic                                  i_clk,
    input  logic                                  i_mul_en,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   i_base,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   i_next,
    input  logic        [lir_pkg::FRAC_W-1:0]     i_frac,
    output logic signed [lir_pkg::SAMPLE_W-1:0]   o_sum
);

    localparam int DIFF_W = lir_pkg::SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + lir_pkg::FRAC_W;

    logic signed [DIFF_W-1:0]             w_diff;
    logic signed [lir_pkg::FRAC_W:0]      w_frac_s;
    logic signed [PROD_W:0]               w_prod;
    logic signed [PROD_W-1:0]             r_prod;
    logic signed [lir_pkg::SAMPLE_W-1:0]  r_base;
    logic signed [DIFF_W-1:0]             w_q;
    logic signed [DIFF_W-1:0]             w_sum;

    assign w_diff   = DIFF_W'(i_next) - DIFF_W'(i_base);
    assign w_frac_s = $signed({1'b0, i_frac});
    assign w_prod   = w_diff * w_frac_s;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= w_prod[PROD_W-1:0];
            r_base <= i_base;
        end
    end

    // floor division by 2^32 is the arithmetic upper slice
    assign w_q   = r_prod[PROD_W-1:lir_pkg::FRAC_W];
    assign w_sum = DIFF_W'(r_base) + w_q;
    assign o_sum = w_sum[lir_pkg::SAMPLE_W-1:0];

endmodule

// ----- src/linear_interp_resampler_core.sv -----
// Channel  Direction  Handshake                    Payload
// in       input      i_in_valid / o_in_ready      i_in_data   (t_in_frame)
// out      output     o_out_valid / i_out_ready    o_out_data  (t_out_frame)
// cfg      input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A priming or skipped frame yields no result.
// An emitting frame yields up to 64 results; for each, the single shared
// multiplier walks the N active channels in turn (multiply, then add per channel).
// The output register lets the next result be computed while one waits.
// Reset is synchronous, active low; config writes take effect at once.
module linear_interp_resampler_core #(
    parameter int MAX_CHANNELS = lir_pkg::MAX_CHANNELS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  lir_pkg::t_in_frame                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output lir_pkg::t_out_frame                o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lir_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lir_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SW = lir_pkg::SAMPLE_W;
    localparam int NL = lir_pkg::NUM_LANES;

    lir_pkg::t_state                 r_state, n_state;
    logic [lir_pkg::CH_W-1:0]        r_ch, n_ch;
    logic [lir_pkg::K_W-1:0]         r_k, n_k;
    logic [lir_pkg::FRAC_W-1:0]      r_frac, n_frac;
    logic [lir_pkg::CARRY_W-1:0]     r_pending, n_pending;
    logic                            r_primed, n_primed;
    logic [lir_pkg::STEP_W-1:0]      r_step, n_step;
    logic [lir_pkg::NCH_W-1:0]       r_act, n_act;
    logic signed [SW-1:0]            r_cur [NL];
    logic signed [SW-1:0]            n_cur [NL];
    logic signed [SW-1:0]            r_prev [NL];
    logic signed [SW-1:0]            n_prev [NL];
    logic signed [SW-1:0]            r_res [NL];
    logic signed [SW-1:0]            n_res [NL];
    lir_pkg::t_out_frame             r_out, n_out;
    logic                            r_out_valid, n_out_valid;

    logic [lir_pkg::NCH_W-1:0]       w_nch;
    logic [lir_pkg::STEP_W:0]        w_acc;
    logic [lir_pkg::CARRY_W-1:0]     w_carry;
    logic                            w_last;
    logic                            w_out_free;
    logic                            w_in_acc;
    logic                            w_mul_en;
    logic signed [SW-1:0]            w_sum;

    assign w_nch = (r_act == '0) ? lir_pkg::NCH_W'(1) :
                   (r_act > lir_pkg::NCH_W'(MAX_CHANNELS)) ?
                   lir_pkg::NCH_W'(MAX_CHANNELS) : r_act;

    assign w_acc      = (lir_pkg::STEP_W + 1)'(r_frac) + (lir_pkg::STEP_W + 1)'(r_step);
    assign w_carry    = w_acc[lir_pkg::STEP_W:lir_pkg::FRAC_W];
    assign w_last     = (w_carry != '0) || (r_k == '1);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign o_in_ready  = (r_state == lir_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    lir_interp_unit u_interp (
        .i_clk    (i_clk),
        .i_mul_en (w_mul_en),
        .i_base   (r_prev[r_ch]),
        .i_next   (r_cur[r_ch]),
        .i_frac   (r_frac),
        .o_sum    (w_sum)
    );

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_k         = r_k;
        n_frac      = r_frac;
        n_pending   = r_pending;
        n_primed    = r_primed;
        n_step      = r_step;
        n_act       = r_act;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_mul_en    = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lir_pkg::REG_PHASE_STEP: n_step = i_cfg_data;
                lir_pkg::REG_ACTIVE_CH:  n_act  = i_cfg_data[lir_pkg::NCH_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            lir_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_cur[0] = i_in_data.sample_ch0;
                    n_cur[1] = i_in_data.sample_ch1;
                    n_cur[2] = i_in_data.sample_ch2;
                    n_cur[3] = i_in_data.sample_ch3;
                    if (!r_primed) begin
                        n_prev   = n_cur;
                        n_primed = 1'b1;
                    end else if (r_pending != '0) begin
                        n_prev    = n_cur;
                        n_pending = r_pending - 1'b1;
                    end else begin
                        n_state = lir_pkg::S_MUL;
                        n_ch    = '0;
                        n_k     = '0;
                    end
                end
            end
            lir_pkg::S_MUL: begin
                w_mul_en = 1'b1;
                n_state  = lir_pkg::S_ADD;
            end
            lir_pkg::S_ADD: begin
                n_res[r_ch] = w_sum;
                if (lir_pkg::NCH_W'(r_ch) + lir_pkg::NCH_W'(1) == w_nch) begin
                    n_state = lir_pkg::S_LOAD;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = lir_pkg::S_MUL;
                end
            end
            lir_pkg::S_LOAD: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.out_ch0     = r_res[0];
                    n_out.out_ch1     = (w_nch > lir_pkg::NCH_W'(1)) ? r_res[1] : '0;
                    n_out.out_ch2     = (w_nch > lir_pkg::NCH_W'(2)) ? r_res[2] : '0;
                    n_out.out_ch3     = (w_nch > lir_pkg::NCH_W'(3)) ? r_res[3] : '0;
                    n_out.last_of_run = w_last;
                    n_frac            = w_acc[lir_pkg::FRAC_W-1:0];
                    n_k               = r_k + 1'b1;
                    n_ch              = '0;
                    if (w_last) begin
                        n_prev    = r_cur;
                        n_pending = (w_carry == '0) ? '0 : w_carry - 1'b1;
                        n_state   = lir_pkg::S_IDLE;
                    end else begin
                        n_state = lir_pkg::S_MUL;
                    end
                end
            end
            default: n_state = lir_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lir_pkg::S_IDLE;
            r_ch        <= '0;
            r_k         <= '0;
            r_frac      <= '0;
            r_pending   <= '0;
            r_primed    <= 1'b0;
            r_step      <= lir_pkg::PHASE_STEP_RST;
            r_act       <= lir_pkg::ACTIVE_CH_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_k         <= n_k;
            r_frac      <= n_frac;
            r_pending   <= n_pending;
            r_primed    <= n_primed;
            r_step      <= n_step;
            r_act       <= n_act;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_prev <= n_prev;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    a_ch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lir_pkg::S_MUL || r_state == lir_pkg::S_ADD)
        |-> (lir_pkg::NCH_W'(r_ch) < w_nch))
        else $error("channel index beyond active count");

    a_pending_needs_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != '0) |-> r_primed)
        else $error("skip count set before priming");

    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_primed && r_pending == '0) |=> (r_state == lir_pkg::S_MUL))
        else $error("emitting transaction did not start the sequencer");

    a_cap_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lir_pkg::S_LOAD && w_out_free && r_k == '1)
        |=> (r_state == lir_pkg::S_IDLE && r_out.last_of_run))
        else $error("result cap did not end the run");

endmodule

// ----- tb/resampler_checker.sv -----
`timescale 1ns / 100ps

module resampler_checker
    import lir_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  t_in_frame              i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_out_frame             i_out_data,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_end_check,
    output int                     o_pending,
    output int                     o_errors
);

    logic [STEP_W-1:0]          phase_step = PHASE_STEP_RST;
    logic [NCH_W-1:0]           chan_count = ACTIVE_CH_RST;
    logic signed [SAMPLE_W-1:0] base_frame [NUM_LANES];
    logic [FRAC_W-1:0]          frac = '0;
    logic [CARRY_W-1:0]         skip_count = '0;
    bit                         primed = 1'b0;
    bit                         leftovers_done = 1'b0;
    int                         checked = 0;
    t_out_frame                 expected_outputs [$];

    task automatic report_mismatch(input string msg);
        o_errors++;
        $display("tb mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] interp_sample(
        input logic signed [SAMPLE_W-1:0] lo,
        input logic signed [SAMPLE_W-1:0] hi,
        input logic [FRAC_W-1:0]          fr
    );
        longint prod;
        prod = (longint'(hi) - longint'(lo)) * longint'({32'd0, fr});
        return SAMPLE_W'(longint'(lo) + (prod >>> FRAC_W));
    endfunction

    task automatic predict_outputs(input t_in_frame f);
        logic signed [SAMPLE_W-1:0] cur [NUM_LANES];
        logic signed [SAMPLE_W-1:0] v [NUM_LANES];
        int                         lanes;
        logic [63:0]                acc;
        logic [63:0]                carry;
        int                         k;
        t_out_frame                 o;
        cur = '{f.sample_ch0, f.sample_ch1, f.sample_ch2, f.sample_ch3};
        lanes = (chan_count == 0) ? 1 : ((chan_count > MAX_CHANNELS) ? MAX_CHANNELS
                                                                      : int'(chan_count));
        if (!primed) begin
            base_frame = cur;
            primed = 1'b1;
            return;
        end
        if (skip_count != 0) begin
            base_frame = cur;
            skip_count--;
            return;
        end
        carry = '0;
        k = 0;
        while (k < RESULT_CAP) begin
            for (int c = 0; c < NUM_LANES; c++)
                v[c] = (c < lanes) ? interp_sample(base_frame[c], cur[c], frac) : '0;
            o = '{out_ch0: v[0], out_ch1: v[1], out_ch2: v[2], out_ch3: v[3],
                  last_of_run: 1'b0};
            acc = {32'd0, frac} + {28'd0, phase_step};
            frac = acc[FRAC_W-1:0];
            carry = acc >> FRAC_W;
            k++;
            if (carry != 0 || k == RESULT_CAP) o.last_of_run = 1'b1;
            expected_outputs.push_back(o);
            if (carry != 0) break;
        end
        if (carry == 0) carry = 1;
        base_frame = cur;
        skip_count = CARRY_W'(carry - 1);
    endtask

    task automatic check_output(input t_out_frame got);
        t_out_frame                 want;
        logic signed [SAMPLE_W-1:0] g [NUM_LANES];
        logic signed [SAMPLE_W-1:0] w [NUM_LANES];
        if (expected_outputs.size() == 0) begin
            report_mismatch($sformatf("output frame %0d arrived with none expected", checked));
            checked++;
            return;
        end
        want = expected_outputs.pop_front();
        g = '{got.out_ch0, got.out_ch1, got.out_ch2, got.out_ch3};
        w = '{want.out_ch0, want.out_ch1, want.out_ch2, want.out_ch3};
        for (int c = 0; c < NUM_LANES; c++)
            if (g[c] !== w[c])
                report_mismatch($sformatf("output frame %0d out_ch%0d: got %0d, expected %0d",
                                          checked, c, g[c], w[c]));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("output frame %0d last_of_run: got %b, expected %b",
                                      checked, got.last_of_run, want.last_of_run));
        checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase_step = PHASE_STEP_RST;
            chan_count = ACTIVE_CH_RST;
            foreach (base_frame[c]) base_frame[c] = '0;
            frac = '0;
            skip_count = '0;
            primed = 1'b0;
            expected_outputs.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_output(i_out_data);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PHASE_STEP: phase_step = i_cfg_data[STEP_W-1:0];
                    REG_ACTIVE_CH:  chan_count = i_cfg_data[NCH_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_outputs(i_in_data);
            if (i_end_check && !leftovers_done) begin
                if (expected_outputs.size() != 0)
                    report_mismatch($sformatf("%0d expected output frames never arrived",
                                              expected_outputs.size()));
                leftovers_done = 1'b1;
            end
        end
        o_pending <= expected_outputs.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import lir_pkg::*;

    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_FRAMES   = 25;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_frame             in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_frame            out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  end_check = 1'b0;
    int                    pending;
    int                    errors;
    bit                    tx_idle = 1'b1;
    bit                    rx_idle = 1'b1;
    int                    frames_sent   = 0;
    int                    results_seen  = 0;
    int                    settings_used = 0;
    int                    quiet_cycles  = 0;

    linear_interp_resampler_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    resampler_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_end_check (end_check),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // output side: when rx_idle is set, stall a random number of cycles before each transaction
    initial begin
        int gap;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            results_seen++;
        end
    end

    function automatic t_in_frame frame4(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c, input logic [15:0] d);
        return '{sample_ch0: a, sample_ch1: b, sample_ch2: c, sample_ch3: d};
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0: return STEP_W'(64'd67108864);
            1: return {STEP_W{1'b1}};
            2: return STEP_W'($urandom_range(0, 67108864));
            3: return {4'($urandom_range(1, 15)), 32'd0};
            4: return {4'($urandom), 32'($urandom)};
            default: return {3'd0, 1'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic send_frame(input t_in_frame f);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        frames_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [STEP_W-1:0] step, input logic [NCH_W-1:0] nch,
                                 input bit junk);
        wait_idle();
        if (junk) cfg_write(CFG_IDX_W'($urandom_range(2, (1 << CFG_IDX_W) - 1)),
                            CFG_DATA_W'({$urandom, $urandom}));
        cfg_write(REG_PHASE_STEP, CFG_DATA_W'(step));
        cfg_write(REG_ACTIVE_CH, CFG_DATA_W'(nch));
        cfg_valid <= 1'b0;
        settings_used++;
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings; first frame primes
        send_frame(frame4(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_frame(frame4(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        send_frame(frame4(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        send_frame(frame4(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001));
        send_frame(frame4(16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF));

        // one result per frame, all channels
        apply_setting({4'd1, 32'd0}, 3'd4, 1'b0);
        send_frame(frame4(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF));
        send_frame(frame4(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000));
        send_frame(frame4(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_frame(frame4(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));

        // lowest step: up to 64 results per frame, carry on the last; zero channels act as one
        apply_setting(STEP_W'(64'd67108864), 3'd0, 1'b1);
        send_frame(frame4(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_frame(frame4(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));

        // zero step hits the result cap; channel count above range
        apply_setting('0, 3'd5, 1'b1);
        send_frame(frame4(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        send_frame(frame4(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));

        // largest step: long skips
        apply_setting({STEP_W{1'b1}}, 3'd7, 1'b0);
        repeat (6) send_frame(frame4(rand_sample(), rand_sample(), rand_sample(),
                                     rand_sample()));

        // half step, top channel inactive
        apply_setting({4'd0, 32'h8000_0000}, 3'd3, 1'b0);
        repeat (4) send_frame(frame4(rand_sample(), rand_sample(), rand_sample(),
                                     rand_sample()));

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            apply_setting(pick_step(), NCH_W'($urandom), 1'($urandom_range(0, 1)));
            repeat (PHASE_FRAMES)
                send_frame(frame4(rand_sample(), rand_sample(), rand_sample(),
                                  rand_sample()));
        end

        wait_idle();
        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        $display("tb: %0d input frames over %0d register settings, %0d output frames checked",
                 frames_sent, settings_used, results_seen);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/lir_pkg.sv
src/lir_interp_unit.sv
src/linear_interp_resampler_core.sv
tb/resampler_checker.sv
tb/tb.sv
